[rtl/mmae_pkg.sv]
// mmae_pkg: shared types and constants of the matrix multiply-accumulate engine
// no dependencies

package mmae_pkg;

   localparam int IDX_W       = 6;
   localparam int MAX_DIM     = 1 << IDX_W;
   localparam int DIM_W       = 7;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int MEM_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int KIND_W      = 2;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 48;
   localparam int PAYLOAD_W   = 2 * IDX_W + WORD_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIM_W-1:0] DIM_RESET    = DIM_W'(64);
   localparam logic [DIM_W-1:0] DIM_CAPACITY = DIM_W'(MAX_DIM);

   typedef enum logic [KIND_W-1:0] {
      KIND_LEFT  = 2'd0,
      KIND_RIGHT = 2'd1,
      KIND_ACC   = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } back_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [WORD_W-1:0]  value;
      logic [IDX_W-1:0]   col;
      logic [IDX_W-1:0]   row;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic [WORD_W-1:0] res_value;
      logic [IDX_W-1:0]  res_col;
      logic [IDX_W-1:0]  res_row;
   } result_type;

endpackage

[rtl/mmae_front.sv]
// mmae_front: size register, range check and drop of out-of-range items
// depends on mmae_pkg

module mmae_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mmae_pkg::DIM_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  mmae_pkg::job_type             req_job,
   input  logic                          queue_full,
   output mmae_pkg::push_type            push,
   output logic [mmae_pkg::DIM_W-1:0]    size_in_use
);
   import mmae_pkg::*;

   logic [DIM_W-1:0] dim_ff;
   logic [DIM_W-1:0] dim_in;
   logic             in_range;

   assign dim_in = csr_we ? csr_wdata : dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   assign size_in_use = (dim_ff > DIM_CAPACITY) ? DIM_CAPACITY : dim_ff;
   assign in_range    = ({1'b0, req_job.row} < size_in_use) &&
                        ({1'b0, req_job.col} < size_in_use);
   assign req_tready  = !queue_full;

   always_comb begin
      push.valid = req_tvalid && req_tready && in_range;
      push.job   = req_job;
   end

endmodule

[rtl/mmae_queue.sv]
// mmae_queue: short job queue between front and back
// depends on mmae_pkg

module mmae_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mmae_pkg::push_type   push,
   output logic                 full,
   output logic                 head_valid,
   output mmae_pkg::job_type    head_job,
   input  logic                 pop
);
   import mmae_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

[rtl/mmae_back.sv]
// mmae_back: matrix stores, shared multiply-accumulate unit and result register
// depends on mmae_pkg

module mmae_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mmae_pkg::DIM_W-1:0]    size_in_use,
   input  logic                          head_valid,
   input  mmae_pkg::job_type             head_job,
   output logic                          head_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output mmae_pkg::result_type          rsp_result
);
   import mmae_pkg::*;

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   k_ff, k_in;

   logic [WORD_W-1:0]  left_mem  [MEM_DEPTH];
   logic [WORD_W-1:0]  right_mem [MEM_DEPTH];
   logic [WORD_W-1:0]  acc_mem   [MEM_DEPTH];

   logic [WORD_W-1:0]  left_q_ff, right_q_ff, acc_q_ff;
   logic [WORD_W-1:0]  prod_ff, sum_ff;
   logic               v1_ff, v2_ff, load_acc_ff;
   logic               out_valid_ff;
   result_type         out_ff;

   logic               start, issue, last_issue, pipe_empty, finish;
   logic [ADDR_W-1:0]  head_addr, left_addr, right_addr;

   assign head_addr  = {head_job.row, head_job.col};
   assign left_addr  = {row_ff, k_ff};
   assign right_addr = {k_ff, col_ff};
   assign pipe_empty = !v1_ff && !v2_ff;

   // control outputs
   always_comb begin
      head_pop   = (state_ff == ST_IDLE) && head_valid;
      start      = head_pop && (head_job.kind == KIND_READ);
      issue      = (state_ff == ST_RUN);
      last_issue = issue && ({1'b0, k_ff} == size_in_use - DIM_W'(1));
      finish     = (state_ff == ST_DRAIN) && pipe_empty &&
                   (!out_valid_ff || rsp_tready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      row_in = start ? head_job.row : row_ff;
      col_in = start ? head_job.col : col_ff;
      k_in   = k_ff;
      if (start) begin
         k_in = '0;
      end else if (issue) begin
         k_in = k_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         load_acc_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         v1_ff       <= issue;
         v2_ff       <= v1_ff;
         load_acc_ff <= start;
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      k_ff    <= k_in;
      prod_ff <= left_q_ff * right_q_ff;
      if (load_acc_ff) begin
         sum_ff <= acc_q_ff;
      end else if (v2_ff) begin
         sum_ff <= sum_ff + prod_ff;
      end
      if (finish) begin
         out_ff.res_row   <= row_ff;
         out_ff.res_col   <= col_ff;
         out_ff.res_value <= sum_ff;
      end
   end

   // matrix stores
   always_ff @(posedge clock) begin
      if (head_pop && (head_job.kind == KIND_LEFT)) begin
         left_mem[head_addr] <= head_job.value;
      end
      left_q_ff <= left_mem[left_addr];
   end

   always_ff @(posedge clock) begin
      if (head_pop && (head_job.kind == KIND_RIGHT)) begin
         right_mem[head_addr] <= head_job.value;
      end
      right_q_ff <= right_mem[right_addr];
   end

   always_ff @(posedge clock) begin
      if (head_pop && (head_job.kind == KIND_ACC)) begin
         acc_mem[head_addr] <= head_job.value;
      end
      acc_q_ff <= acc_mem[head_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

[rtl/matrix_multiply_accumulate_engine.sv]
// matrix_multiply_accumulate_engine: top level, result = accumulator + left * right
// depends on mmae_pkg, mmae_front, mmae_queue, mmae_back
//
//   channel   direction   payload
//   req       in          tuser: kind; tdata: row, col, value
//   rsp       out         tdata: res_row, res_col, res_value
//   csr       in          wdata: dim_in_use, written when csr_we is high
//
// a load is written straight into its store from the queue head; a result request runs
// size_in_use multiply-accumulates, one per cycle on the single shared unit
// the matrix stores are not cleared by reset; only control state is
// a two-entry queue lets the front accept while the back is busy, and the
// result register frees the back end while rsp is stalled

module matrix_multiply_accumulate_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mmae_pkg::DIM_W-1:0]          csr_wdata,   // dim_in_use
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mmae_pkg::REQ_DATA_W-1:0]     req_tdata,   // row, col, value, zero pad
   input  logic [mmae_pkg::KIND_W-1:0]         req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mmae_pkg::RSP_DATA_W-1:0]     rsp_tdata    // res_row, res_col, res_value, zero pad
);
   import mmae_pkg::*;

   job_type           req_job;
   push_type          push;
   logic              queue_full;
   logic              head_valid;
   job_type           head_job;
   logic              head_pop;
   logic [DIM_W-1:0]  size_in_use;
   result_type        rsp_result;

   always_comb begin
      req_job.row   = req_tdata[IDX_W-1:0];
      req_job.col   = req_tdata[2*IDX_W-1:IDX_W];
      req_job.value = req_tdata[PAYLOAD_W-1:2*IDX_W];
      req_job.kind  = kind_type'(req_tuser);
   end

   assign rsp_tdata = {{(RSP_DATA_W-PAYLOAD_W){1'b0}}, rsp_result};

   mmae_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_job     (req_job),
      .queue_full  (queue_full),
      .push        (push),
      .size_in_use (size_in_use)
   );

   mmae_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (head_pop)
   );

   mmae_back u_back (
      .clock       (clock),
      .reset       (reset),
      .size_in_use (size_in_use),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .head_pop    (head_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (rsp_result)
   );

endmodule

[rtl/mmae_checker.sv]
// mmae_checker: port-level checks of the engine, bound to the top level
// depends on mmae_pkg

module mmae_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mmae_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mmae_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transfer changed");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a result needs a request to travel through queue and back end
   assert property (@(posedge clock)
      reset |-> ##2 !rsp_tvalid)
      else $error("rsp valid too soon after reset");

   // pad bits of a result stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:PAYLOAD_W] == '0)
      else $error("rsp pad bits set");

   // front is ready right after reset
   assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

endmodule

bind matrix_multiply_accumulate_engine mmae_checker u_mmae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/matrix_multiply_accumulate_engine_tb.sv]
// matrix_multiply_accumulate_engine_tb: self-checking bench for the multiply-accumulate engine
// directed table then random load/request sequences over several sizes, checked by a predictor
// depends on mmae_pkg and matrix_multiply_accumulate_engine
`timescale 1ns / 1ps

module matrix_multiply_accumulate_engine_tb;
   import mmae_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [DIM_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // row, col, value, zero pad
   logic [KIND_W-1:0]     req_tuser = '0;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // res_row, res_col, res_value, zero pad

   matrix_multiply_accumulate_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [WORD_W-1:0] left_m  [MEM_DEPTH];
   logic [WORD_W-1:0] right_m [MEM_DEPTH];
   logic [WORD_W-1:0] acc_m   [MEM_DEPTH];
   bit                left_set  [MEM_DEPTH];
   bit                right_set [MEM_DEPTH];
   bit                acc_set   [MEM_DEPTH];
   logic [DIM_W-1:0]  dim_reg = DIM_RESET;

   result_type pending_results [$];
   int         mismatches = 0;
   int         results_seen = 0;
   int         counted_items = 0;
   bit         no_gaps = 1'b0;
   int         hold_cycles = 0;
   int         steady_cycles = 0;
   bit         long_hold_done = 1'b0;

   typedef struct {
      bit                is_cfg;
      logic [DIM_W-1:0]  dim;
      kind_type          kind;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [WORD_W-1:0] value;
      bit                typed;
      logic [WORD_W-1:0] want;
   } step_type;

   step_type directed_steps [$] = '{
      '{1, 1,   KIND_LEFT,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_LEFT,  0,  0,  3,            0, 0},
      '{0, 0,   KIND_RIGHT, 0,  0,  5,            0, 0},
      '{0, 0,   KIND_ACC,   0,  0,  7,            0, 0},
      '{0, 0,   KIND_READ,  0,  0,  0,            1, 22},
      '{0, 0,   KIND_LEFT,  0,  0,  32'h7fffffff, 0, 0},
      '{0, 0,   KIND_RIGHT, 0,  0,  32'h7fffffff, 0, 0},
      '{0, 0,   KIND_ACC,   0,  0,  0,            0, 0},
      '{0, 0,   KIND_READ,  0,  0,  32'hffffffff, 1, 1},
      '{0, 0,   KIND_LEFT,  0,  0,  32'h80000000, 0, 0},
      '{0, 0,   KIND_RIGHT, 0,  0,  32'h80000000, 0, 0},
      '{0, 0,   KIND_ACC,   0,  0,  32'hffffffff, 0, 0},
      '{0, 0,   KIND_READ,  0,  0,  0,            1, 32'hffffffff},
      '{0, 0,   KIND_READ,  0,  1,  0,            0, 0},
      '{0, 0,   KIND_READ,  63, 0,  0,            0, 0},
      '{0, 0,   KIND_LEFT,  1,  0,  1234,         0, 0},
      '{1, 0,   KIND_LEFT,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_READ,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_ACC,   0,  0,  5,            0, 0},
      '{1, 1,   KIND_LEFT,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_READ,  0,  0,  0,            1, 32'hffffffff},
      '{1, 2,   KIND_LEFT,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_LEFT,  0,  1,  32'hffffffff, 0, 0},
      '{0, 0,   KIND_RIGHT, 1,  0,  3,            0, 0},
      '{0, 0,   KIND_READ,  0,  0,  32'h5a5a5a5a, 0, 0},
      '{1, 127, KIND_LEFT,  0,  0,  0,            0, 0},
      '{0, 0,   KIND_LEFT,  63, 63, 32'hffffffff, 0, 0},
      '{0, 0,   KIND_RIGHT, 63, 0,  32'h55555555, 0, 0},
      '{0, 0,   KIND_ACC,   0,  63, 32'haaaaaaaa, 0, 0}
   };

   int phase_dims [$] = '{4, 1, 2, 64, 3, 127, 8, 5, 0, 16, 7, 2, 6};

   function automatic int size_now();
      return (dim_reg > DIM_CAPACITY) ? MAX_DIM : int'(dim_reg);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 32'hffffffff;
         4: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      int pick;
      if (no_gaps) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic mac_predict(input kind_type kind, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [WORD_W-1:0] value,
                              input bit typed, input logic [WORD_W-1:0] want);
      int                n;
      int                addr;
      logic [WORD_W-1:0] sum;
      result_type        res;
      n = size_now();
      if (row >= n || col >= n) return;
      addr = row * MAX_DIM + col;
      case (kind)
         KIND_LEFT: begin
            left_m[addr] = value;
            left_set[addr] = 1'b1;
         end
         KIND_RIGHT: begin
            right_m[addr] = value;
            right_set[addr] = 1'b1;
         end
         KIND_ACC: begin
            acc_m[addr] = value;
            acc_set[addr] = 1'b1;
         end
         default: begin
            sum = acc_m[addr];
            for (int k = 0; k < n; k++)
               sum = sum + left_m[row * MAX_DIM + k] * right_m[k * MAX_DIM + col];
            res.res_row = row;
            res.res_col = col;
            res.res_value = typed ? want : sum;
            pending_results.push_back(res);
         end
      endcase
   endtask

   task automatic send_item(input kind_type kind, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [WORD_W-1:0] value,
                            input bit typed = 1'b0, input logic [WORD_W-1:0] want = '0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - PAYLOAD_W){1'b0}}, value, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      counted_items++;
      mac_predict(kind, row, col, value, typed, want);
   endtask

   // register writes only once the engine has drained
   task automatic set_dim(input logic [DIM_W-1:0] dim);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= dim;
      @(posedge clock);
      csr_we  <= 1'b0;
      dim_reg = dim;
   endtask

   // one request preceded by whatever loads it needs, sometimes rewriting its operands
   task automatic run_request(input int n);
      int r, c, k;
      if (n > 8) begin
         r = $urandom_range(0, 1) ? n - 1 : 0;
         c = $urandom_range(0, 1) ? n - 1 : 0;
      end else begin
         r = $urandom_range(0, n - 1);
         c = $urandom_range(0, n - 1);
      end
      repeat ($urandom_range(0, 3)) begin
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 2))
            0: send_item(KIND_LEFT, IDX_W'(r), IDX_W'(k), rand_word());
            1: send_item(KIND_RIGHT, IDX_W'(k), IDX_W'(c), rand_word());
            default: send_item(KIND_ACC, IDX_W'(r), IDX_W'(c), rand_word());
         endcase
      end
      for (k = 0; k < n; k++) begin
         if (!left_set[r * MAX_DIM + k])
            send_item(KIND_LEFT, IDX_W'(r), IDX_W'(k), rand_word());
         if (!right_set[k * MAX_DIM + c])
            send_item(KIND_RIGHT, IDX_W'(k), IDX_W'(c), rand_word());
      end
      if (!acc_set[r * MAX_DIM + c]) send_item(KIND_ACC, IDX_W'(r), IDX_W'(c), rand_word());
      send_item(KIND_READ, IDX_W'(r), IDX_W'(c), $urandom);
      if ($urandom_range(0, 3) == 0) send_item(KIND_READ, IDX_W'(r), IDX_W'(c), $urandom);
   endtask

   initial begin : stimulus
      int               p;
      int               n;
      int               phase_start;
      logic [DIM_W-1:0] dim;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg)
            set_dim(directed_steps[i].dim);
         else
            send_item(directed_steps[i].kind, directed_steps[i].row, directed_steps[i].col,
                      directed_steps[i].value, directed_steps[i].typed, directed_steps[i].want);
      end

      counted_items = 0;
      p = 0;
      while (counted_items < 450) begin
         dim = (p < phase_dims.size()) ? DIM_W'(phase_dims[p]) : DIM_W'($urandom_range(1, 10));
         p++;
         set_dim(dim);
         no_gaps = ($urandom_range(0, 3) == 0);
         n = size_now();
         if (n == 0) begin
            repeat (8)
               send_item(kind_type'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 63)),
                         IDX_W'($urandom_range(0, 63)), rand_word());
         end else begin
            phase_start = counted_items;
            while (counted_items - phase_start < 45) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: run_request(n);
                  8: begin
                     if (n < MAX_DIM)
                        send_item(KIND_READ, IDX_W'($urandom_range(n, 63)),
                                  IDX_W'($urandom_range(0, 63)), $urandom);
                     else
                        send_item(kind_type'($urandom_range(0, 2)),
                                  IDX_W'($urandom_range(0, 63)),
                                  IDX_W'($urandom_range(0, 63)), rand_word());
                  end
                  9: send_item(kind_type'($urandom_range(0, 2)),
                               IDX_W'($urandom_range(0, n - 1)),
                               IDX_W'($urandom_range(0, n - 1)), rand_word());
                  default: send_item(kind_type'($urandom_range(0, 2)),
                                     IDX_W'($urandom_range(0, 63)),
                                     IDX_W'($urandom_range(0, 63)), rand_word());
               endcase
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result checking and receiver back-pressure
   always @(posedge clock) begin : rsp_side
      result_type got;
      result_type want;
      int         pick;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[PAYLOAD_W-1:0];
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("unexpected rsp transfer: row %0d col %0d value %h",
                      got.res_row, got.res_col, got.res_value);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.res_row !== want.res_row) begin
                  $error("res_row expected %0d got %0d", want.res_row, got.res_row);
                  mismatches++;
               end
               if (got.res_col !== want.res_col) begin
                  $error("res_col expected %0d got %0d", want.res_col, got.res_col);
                  mismatches++;
               end
               if (got.res_value !== want.res_value) begin
                  $error("res_value expected %h got %h", want.res_value, got.res_value);
                  mismatches++;
               end
            end
         end

         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 12 && req_tvalid) begin
            // long stall so the queue fills and req_tready drops
            long_hold_done = 1'b1;
            hold_cycles = 400;
            rsp_tready <= 1'b0;
         end else if (steady_cycles > 0) begin
            steady_cycles--;
            rsp_tready <= 1'b1;
         end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               hold_cycles = $urandom_range(10, 40);
            else if (pick < 4)
               hold_cycles = $urandom_range(1, 3);
            else if (pick == 4)
               steady_cycles = $urandom_range(20, 80);
            rsp_tready <= (hold_cycles == 0);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/mmae_pkg.sv
rtl/mmae_front.sv
rtl/mmae_queue.sv
rtl/mmae_back.sv
rtl/matrix_multiply_accumulate_engine.sv
rtl/mmae_checker.sv
tb/sv/matrix_multiply_accumulate_engine_tb.sv
